// ----- rtl/marker_hex_length_frame_receiver_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the marker hex length frame receiver
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef MARKER_HEX_LENGTH_FRAME_RECEIVER_ASSERT_SVH
`define MARKER_HEX_LENGTH_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication.
`define MHLFR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MHLFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mhlfr_pkg.sv -----
// ----------------------------------------------------------------------------
// mhlfr_pkg
// Types, codes and helper functions shared by the frame receiver modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mhlfr_pkg;

	localparam int SIZE_DIGITS      = 8;
	localparam int MARKER_BYTES_MAX = 8;
	localparam int FIFO_DEPTH       = 4;

	localparam logic [31:0] FNV_OFFSET = 32'h811C_9DC5;
	localparam logic [31:0] FNV_PRIME  = 32'd16777619;

	// Configuration register indexes
	localparam logic [2:0] REG_START_MARKER    = 3'd0;
	localparam logic [2:0] REG_START_LENGTH    = 3'd1;
	localparam logic [2:0] REG_END_MARKER      = 3'd2;
	localparam logic [2:0] REG_END_LENGTH      = 3'd3;
	localparam logic [2:0] REG_DELIMITER       = 3'd4;
	localparam logic [2:0] REG_MAX_PAYLOAD     = 3'd5;
	localparam logic [2:0] REG_BUFFER_CAPACITY = 3'd6;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_DIGITS,
		PH_DELIM,
		PH_PAYLOAD,
		PH_END
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_READ_ERROR  = 3'd1,
		ST_BAD_SIZE    = 3'd2,
		ST_BAD_DELIM   = 3'd3,
		ST_BUF_SMALL   = 3'd4,
		ST_BAD_END     = 3'd5
	} status_t;

	typedef enum logic {
		CMD_DATA,
		CMD_STATUS
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;
		status_t     code;
		logic [31:0] length;
	} cmd_t;

	typedef struct packed {
		logic [63:0] start_marker;
		logic [3:0]  start_length;
		logic [63:0] end_marker;
		logic [3:0]  end_length;
		logic [7:0]  delimiter_byte;
		logic [31:0] max_payload;
		logic [31:0] buffer_capacity;
	} cfg_t;

	// One FNV-1a round: xor the byte in, then multiply by the prime.
	function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return x * FNV_PRIME;
	endfunction

endpackage

// ----- rtl/mhlfr_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// mhlfr_cmd_fifo
// Short command queue between the byte classifier and the result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "marker_hex_length_frame_receiver_assert.svh"

module mhlfr_cmd_fifo #(
	parameter int DEPTH = mhlfr_pkg::FIFO_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  mhlfr_pkg::cmd_t wr_data,
	input  logic            rd,
	output mhlfr_pkg::cmd_t rd_data,
	output logic            not_empty,
	output logic            full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	mhlfr_pkg::cmd_t  entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd_data   = entries_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == DEPTH_CNT);

	always_ff @(posedge clk) begin
		if (wr) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`MHLFR_ASSERT_IMPLIES(a_count_in_range, clk, arst_n, 1'b1, count_q <= DEPTH_CNT, "fifo count beyond depth")
	`MHLFR_ASSERT_NEXT(a_count_grows, clk, arst_n, wr && !rd, count_q == $past(count_q) + 1'b1, "fifo count did not follow a lone write")

endmodule

// ----- rtl/mhlfr_front.sv -----
// ----------------------------------------------------------------------------
// mhlfr_front
// Byte classifier: marker hunt, hex length header, delimiter and end marker
// checks. Issues one command per byte that gives a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "marker_hex_length_frame_receiver_assert.svh"

module mhlfr_front (
	input  logic            clk,
	input  logic            arst_n,
	input  mhlfr_pkg::cfg_t cfg,
	input  logic            take,
	input  logic [7:0]      rx_byte,
	input  logic            rx_error,
	output logic            cmd_wr,
	output mhlfr_pkg::cmd_t cmd
);

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_F    = 8'h46;
	localparam logic [3:0] HEX_TEN_OFFSET = 4'd9;
	localparam logic [3:0] SIZE_DIGITS_N  = 4'(mhlfr_pkg::SIZE_DIGITS);
	localparam logic [3:0] MARKER_MAX_N   = 4'(mhlfr_pkg::MARKER_BYTES_MAX);

	function automatic logic [3:0] used_length(input logic [3:0] len);
		if (len == 4'd0) begin
			return 4'd1;
		end else if (len > MARKER_MAX_N) begin
			return MARKER_MAX_N;
		end
		return len;
	endfunction

	function automatic logic [7:0] marker_byte(input logic [63:0] marker, input logic [2:0] idx);
		logic [63:0] shifted;
		shifted = marker >> {idx, 3'b000};
		return shifted[7:0];
	endfunction

	mhlfr_pkg::phase_t phase_q, phase_d;
	logic [3:0]  idx_q, idx_d;
	logic [3:0]  digit_q, digit_d;
	logic [31:0] length_q, length_d;
	logic [31:0] left_q, left_d;
	logic        bad_q, bad_d;

	logic [3:0]  start_used;
	logic [3:0]  end_used;
	logic [3:0]  hunt_idx;
	logic [3:0]  hunt_next;
	logic        digit_ok;
	logic [3:0]  nib;
	logic [31:0] len_next;
	logic [3:0]  digit_next;
	logic [31:0] left_next;
	logic [3:0]  end_next;
	logic        end_hit;

	assign start_used = used_length(cfg.start_length);
	assign end_used   = used_length(cfg.end_length);
	assign hunt_idx   = (idx_q >= start_used) ? 4'd0 : idx_q;

	// A mismatch may still be the first byte of a fresh marker.
	always_comb begin
		if (rx_byte == marker_byte(cfg.start_marker, hunt_idx[2:0])) begin
			hunt_next = hunt_idx + 4'd1;
		end else if (rx_byte == marker_byte(cfg.start_marker, 3'd0)) begin
			hunt_next = 4'd1;
		end else begin
			hunt_next = 4'd0;
		end
	end

	always_comb begin
		digit_ok = 1'b1;
		nib      = 4'd0;
		if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) begin
			nib = rx_byte[3:0];
		end else if (rx_byte >= CH_A && rx_byte <= CH_F) begin
			nib = rx_byte[3:0] + HEX_TEN_OFFSET;
		end else begin
			digit_ok = 1'b0;
		end
	end

	assign len_next   = {length_q[27:0], nib};
	assign digit_next = digit_q + 4'd1;
	assign left_next  = left_q - 32'd1;
	assign end_next   = idx_q + 4'd1;
	assign end_hit    = (rx_byte == marker_byte(cfg.end_marker, idx_q[2:0]));

	always_comb begin
		phase_d  = phase_q;
		idx_d    = idx_q;
		digit_d  = digit_q;
		length_d = length_q;
		left_d   = left_q;
		bad_d    = bad_q;
		cmd_wr   = 1'b0;
		cmd      = '{kind: mhlfr_pkg::CMD_STATUS, data: rx_byte,
			code: mhlfr_pkg::ST_OK, length: 32'd0};
		if (take) begin
			if (rx_error) begin
				cmd_wr    = 1'b1;
				cmd.code  = mhlfr_pkg::ST_READ_ERROR;
			end else begin
				unique case (phase_q)
					mhlfr_pkg::PH_HUNT: begin
						idx_d = hunt_next;
						if (hunt_next >= start_used) begin
							phase_d  = mhlfr_pkg::PH_DIGITS;
							idx_d    = 4'd0;
							digit_d  = 4'd0;
							length_d = 32'd0;
							bad_d    = 1'b0;
						end
					end
					mhlfr_pkg::PH_DIGITS: begin
						length_d = len_next;
						digit_d  = digit_next;
						bad_d    = bad_q | !digit_ok;
						if (digit_next >= SIZE_DIGITS_N) begin
							if (bad_q || !digit_ok || len_next > cfg.max_payload) begin
								cmd_wr   = 1'b1;
								cmd.code = mhlfr_pkg::ST_BAD_SIZE;
							end else begin
								phase_d = mhlfr_pkg::PH_DELIM;
							end
						end
					end
					mhlfr_pkg::PH_DELIM: begin
						if (rx_byte != cfg.delimiter_byte) begin
							cmd_wr   = 1'b1;
							cmd.code = mhlfr_pkg::ST_BAD_DELIM;
						end else if (cfg.buffer_capacity < length_q) begin
							cmd_wr   = 1'b1;
							cmd.code = mhlfr_pkg::ST_BUF_SMALL;
						end else begin
							left_d  = length_q;
							idx_d   = 4'd0;
							phase_d = (length_q == 32'd0) ? mhlfr_pkg::PH_END
								: mhlfr_pkg::PH_PAYLOAD;
						end
					end
					mhlfr_pkg::PH_PAYLOAD: begin
						cmd_wr   = 1'b1;
						cmd.kind = mhlfr_pkg::CMD_DATA;
						left_d   = left_next;
						if (left_next == 32'd0) begin
							phase_d = mhlfr_pkg::PH_END;
							idx_d   = 4'd0;
						end
					end
					mhlfr_pkg::PH_END: begin
						idx_d = end_next;
						if (!end_hit) begin
							cmd_wr   = 1'b1;
							cmd.code = mhlfr_pkg::ST_BAD_END;
						end else if (end_next >= end_used) begin
							cmd_wr     = 1'b1;
							cmd.code   = mhlfr_pkg::ST_OK;
							cmd.length = length_q;
						end
					end
					default: begin
						phase_d = mhlfr_pkg::PH_HUNT;
					end
				endcase
			end
			// Every status transfer ends the frame and restarts the hunt.
			if (cmd_wr && cmd.kind == mhlfr_pkg::CMD_STATUS) begin
				phase_d  = mhlfr_pkg::PH_HUNT;
				idx_d    = 4'd0;
				digit_d  = 4'd0;
				length_d = 32'd0;
				left_d   = 32'd0;
				bad_d    = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mhlfr_pkg::PH_HUNT;
			idx_q    <= 4'd0;
			digit_q  <= 4'd0;
			length_q <= 32'd0;
			left_q   <= 32'd0;
			bad_q    <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			idx_q    <= idx_d;
			digit_q  <= digit_d;
			length_q <= length_d;
			left_q   <= left_d;
			bad_q    <= bad_d;
		end
	end

	`MHLFR_ASSERT_IMPLIES(a_payload_has_bytes, clk, arst_n, phase_q == mhlfr_pkg::PH_PAYLOAD, left_q != 32'd0, "payload phase with no bytes left")
	`MHLFR_ASSERT_IMPLIES(a_digit_count_bounded, clk, arst_n, phase_q == mhlfr_pkg::PH_DIGITS, digit_q < SIZE_DIGITS_N, "digit count ran past the header size")

endmodule

// ----- rtl/mhlfr_back.sv -----
// ----------------------------------------------------------------------------
// mhlfr_back
// Result stage: folds payload bytes into the FNV-1a hash and holds the
// oldest result in an output register until it is popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "marker_hex_length_frame_receiver_assert.svh"

module mhlfr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  mhlfr_pkg::cmd_t cmd,
	output logic            cmd_rd,
	input  logic            pop,
	output logic            empty,
	output logic            is_status,
	output logic [7:0]      data_byte,
	output logic [2:0]      status,
	output logic [31:0]     payload_length,
	output logic [31:0]     checksum
);

	logic        out_valid_q;
	logic [31:0] hash_q;
	logic        is_status_q;
	logic [7:0]  data_q;
	logic [2:0]  status_q;
	logic [31:0] length_q;
	logic [31:0] checksum_q;

	// The output register refills in the same cycle as it is popped, when the queue holds a command.
	assign cmd_rd = cmd_valid && (!out_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hash_q      <= mhlfr_pkg::FNV_OFFSET;
		end else begin
			if (cmd_rd) begin
				out_valid_q <= 1'b1;
				if (cmd.kind == mhlfr_pkg::CMD_DATA) begin
					hash_q <= mhlfr_pkg::fnv_step(hash_q, cmd.data);
				end else begin
					hash_q <= mhlfr_pkg::FNV_OFFSET;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_rd) begin
			if (cmd.kind == mhlfr_pkg::CMD_DATA) begin
				is_status_q <= 1'b0;
				data_q      <= cmd.data;
				status_q    <= 3'd0;
				length_q    <= 32'd0;
				checksum_q  <= 32'd0;
			end else begin
				is_status_q <= 1'b1;
				data_q      <= 8'd0;
				status_q    <= cmd.code;
				length_q    <= cmd.length;
				checksum_q  <= (cmd.code == mhlfr_pkg::ST_OK) ? hash_q : 32'd0;
			end
		end
	end

	assign empty          = !out_valid_q;
	assign is_status      = is_status_q;
	assign data_byte      = data_q;
	assign status         = status_q;
	assign payload_length = length_q;
	assign checksum       = checksum_q;

	`MHLFR_ASSERT_NEXT(a_hash_restarts, clk, arst_n, cmd_rd && cmd.kind == mhlfr_pkg::CMD_STATUS, hash_q == mhlfr_pkg::FNV_OFFSET, "hash not restarted after a status")

endmodule

// ----- rtl/marker_hex_length_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// marker_hex_length_frame_receiver
// Framed byte-stream receiver with hex length header and FNV-1a hash.
// ----------------------------------------------------------------------------
// Link bytes enter through a queue-style port: a transfer happens when push
// is high and full is low, carrying rx_byte and rx_error. Results leave the
// same way: while empty is low the oldest result sits on the result ports,
// and it is taken when pop is high. A payload byte gives one data result; a
// frame ends with one status result, carrying length and hash when it is ok.
// The block takes one byte every cycle while full is low. A result reaches the
// result ports through the queue and the output register: the classifier writes
// its command into the queue at the accepting edge, and the hash unit loads the
// output register once it is empty or being popped. If the receiver stops popping,
// the command queue fills once it holds FIFO_DEPTH commands and full rises, so the
// sender stalls without any loss. Bytes that give no result never occupy the
// queue. Configuration registers are written over cfg_valid/cfg_ready, which is
// always ready; write them only while the block is idle.
// Reset clears the queue and the output register and returns to hunting for
// the start marker with the configuration at its reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module marker_hex_length_frame_receiver #(
	parameter int FIFO_DEPTH = mhlfr_pkg::FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	input  logic        rx_error,
	output logic        empty,
	input  logic        pop,
	output logic        is_status,
	output logic [7:0]  data_byte,
	output logic [2:0]  status,
	output logic [31:0] payload_length,
	output logic [31:0] checksum,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	mhlfr_pkg::cfg_t cfg_q;
	mhlfr_pkg::cmd_t front_cmd;
	mhlfr_pkg::cmd_t queue_cmd;
	logic            take;
	logic            front_wr;
	logic            queue_valid;
	logic            queue_rd;
	logic            queue_full;

	assign cfg_ready = 1'b1;
	assign full      = queue_full;
	assign take      = push && !queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker    <= 64'd0;
			cfg_q.start_length    <= 4'd1;
			cfg_q.end_marker      <= 64'd0;
			cfg_q.end_length      <= 4'd1;
			cfg_q.delimiter_byte  <= 8'd0;
			cfg_q.max_payload     <= 32'hFFFF_FFFF;
			cfg_q.buffer_capacity <= 32'hFFFF_FFFF;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mhlfr_pkg::REG_START_MARKER:    cfg_q.start_marker    <= cfg_data;
				mhlfr_pkg::REG_START_LENGTH:    cfg_q.start_length    <= cfg_data[3:0];
				mhlfr_pkg::REG_END_MARKER:      cfg_q.end_marker      <= cfg_data;
				mhlfr_pkg::REG_END_LENGTH:      cfg_q.end_length      <= cfg_data[3:0];
				mhlfr_pkg::REG_DELIMITER:       cfg_q.delimiter_byte  <= cfg_data[7:0];
				mhlfr_pkg::REG_MAX_PAYLOAD:     cfg_q.max_payload     <= cfg_data[31:0];
				mhlfr_pkg::REG_BUFFER_CAPACITY: cfg_q.buffer_capacity <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	mhlfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.take     (take),
		.rx_byte  (rx_byte),
		.rx_error (rx_error),
		.cmd_wr   (front_wr),
		.cmd      (front_cmd)
	);

	mhlfr_cmd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (front_wr),
		.wr_data   (front_cmd),
		.rd        (queue_rd),
		.rd_data   (queue_cmd),
		.not_empty (queue_valid),
		.full      (queue_full)
	);

	mhlfr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (queue_valid),
		.cmd            (queue_cmd),
		.cmd_rd         (queue_rd),
		.pop            (pop),
		.empty          (empty),
		.is_status      (is_status),
		.data_byte      (data_byte),
		.status         (status),
		.payload_length (payload_length),
		.checksum       (checksum)
	);

endmodule
